@@ src/pac_pkg.sv @@
// Package for the packet airtime calculator: payload structs, status codes,
// bandwidth and spreading factor tables. No dependencies.
`default_nettype none

package pac_pkg;

   localparam int DIVIDEND_W = 52;
   localparam int DIVISOR_W  = 21;
   localparam int QUOT_W     = 32;
   localparam int SYNC_W     = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [SYNC_W-1:0]     SYNC_RESET   = 4'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_SYNC = 3'd0;

   localparam logic [1:0] MOD_CHIRP = 2'd0;
   localparam logic [1:0] MOD_FSK   = 2'd1;

   localparam logic [18:0] SF_MIN = 19'd7;
   localparam logic [18:0] SF_MAX = 19'd12;

   localparam logic [22:0] CHIRP_SCALE = 23'd1000000;  // microseconds per second
   localparam logic [22:0] FSK_SCALE   = 23'd8000000;  // bits per byte times us per s

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_BW    = 3'd1,
      STATUS_BAD_SF    = 3'd2,
      STATUS_BAD_MOD   = 3'd3,
      STATUS_ZERO_RATE = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]  modulation;
      logic [2:0]  bandwidth_code;
      logic [18:0] rate_value;
      logic [2:0]  coding_rate;
      logic [15:0] preamble_len;
      logic [7:0]  payload_bytes;
      logic        crc_off;
      logic        header_off;
   } req_type;

   typedef struct packed {
      logic [31:0] airtime_us;
      status_type  status;
   } rsp_type;

   // operands handed from the front end to the divider
   typedef struct packed {
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
      status_type            status;
      logic                  fsk;
   } op_type;

   // four times the bandwidth in Hz
   function automatic logic [DIVISOR_W-1:0] bw_quad(input logic [2:0] code);
      logic [DIVISOR_W-1:0] r;
      unique case (code)
         3'd0:    r = 21'd2000000;
         3'd1:    r = 21'd1000000;
         3'd2:    r = 21'd500000;
         3'd3:    r = 21'd250000;
         3'd4:    r = 21'd124800;
         3'd5:    r = 21'd62400;
         3'd6:    r = 21'd31200;
         default: r = '0;
      endcase
      return r;
   endfunction

   // ceil(2^20 / den), den = 4*(SF - 2*DE)
   function automatic logic [15:0] sf_recip(input logic [3:0] sf);
      logic [15:0] r;
      unique case (sf)
         4'd8:         r = 16'd32768;
         4'd9, 4'd11:  r = 16'd29128;
         4'd10, 4'd12: r = 16'd26215;
         default:      r = 16'd37450;
      endcase
      return r;
   endfunction

   // den - 1, turns the floor into a ceiling
   function automatic logic [5:0] sf_den_m1(input logic [3:0] sf);
      logic [5:0] r;
      unique case (sf)
         4'd8:         r = 6'd31;
         4'd9, 4'd11:  r = 6'd35;
         4'd10, 4'd12: r = 6'd39;
         default:      r = 6'd27;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ src/packet_airtime_calculator.sv @@
// Packet airtime calculator top: front end, operand queue, divider, and the
// sync byte register. Depends on pac_pkg, pac_front, pac_ram_queue, pac_divider.
// Throughput: one descriptor per cycle when not stalled (32-stage divider).
// Reset (synchronous): empties all stages and the queue, sync bytes back to 3.
`default_nettype none

module packet_airtime_calculator #(
   parameter int QUEUE_DEPTH = pac_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push,
   output logic                                 full,
   input  wire pac_pkg::req_type                req_data,
   output logic                                 empty,
   input  wire logic                            pop,
   output pac_pkg::rsp_type                     rsp_data,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [pac_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [pac_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [pac_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);

   logic [pac_pkg::SYNC_W-1:0] sync_ff, sync_in;
   logic                       q_push, q_pop, q_full, q_empty;
   pac_pkg::op_type            q_wr_data, q_rd_data;

   assign pready = 1'b1;
   assign prdata = (paddr == pac_pkg::CSR_ADDR_SYNC)
                   ? pac_pkg::CSR_DATA_W'(sync_ff) : '0;

   always_comb begin
      sync_in = sync_ff;
      if (psel && penable && pwrite && pready && paddr == pac_pkg::CSR_ADDR_SYNC) begin
         sync_in = pwdata[pac_pkg::SYNC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= pac_pkg::SYNC_RESET;
      end else begin
         sync_ff <= sync_in;
      end
   end

   pac_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .req_data   (req_data),
      .full       (full),
      .sync_bytes (sync_ff),
      .q_push     (q_push),
      .q_data     (q_wr_data),
      .q_full     (q_full)
   );

   pac_ram_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .empty     (q_empty)
   );

   pac_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_rd_data),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.status != pac_pkg::STATUS_OK) |-> rsp_data.airtime_us == '0)
      else $error("error result carries nonzero airtime");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      full |-> q_full)
      else $error("front end stalled without queue back-pressure");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("transfer into full operand queue");

   a_pop_feeds: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("divider took from empty operand queue");

endmodule

`default_nettype wire

@@ src/pac_ram_queue.sv @@
// Short operand queue between front end and divider.
// Depends on pac_pkg for the operand struct.
`default_nettype none

module pac_ram_queue #(
   parameter int DEPTH = pac_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire pac_pkg::op_type push_data,
   output logic                 full,
   input  wire logic            pop,
   output pac_pkg::op_type      pop_data,
   output logic                 empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   pac_pkg::op_type  entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ src/pac_front.sv @@
// Front end: accepts descriptors, checks codes, and builds dividend and divisor
// over four stages. Depends on pac_pkg.
`default_nettype none

module pac_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire pac_pkg::req_type            req_data,
   output logic                             full,
   input  wire logic [pac_pkg::SYNC_W-1:0]  sync_bytes,
   output logic                             q_push,
   output pac_pkg::op_type                  q_data,
   input  wire logic                        q_full
);

   typedef struct packed {
      pac_pkg::status_type             status;
      logic                            fsk;
      logic [3:0]                      sf;
      logic [2:0]                      cr;
      logic [15:0]                     pre;
      logic [12:0]                     qnum;
      logic [15:0]                     recip;
      logic [16:0]                     bytes;
      logic [pac_pkg::DIVISOR_W-1:0]   divisor;
   } f1_type;

   typedef struct packed {
      pac_pkg::status_type             status;
      logic                            fsk;
      logic [3:0]                      sf;
      logic [2:0]                      cr;
      logic [15:0]                     pre;
      logic [6:0]                      q;
      logic [16:0]                     bytes;
      logic [pac_pkg::DIVISOR_W-1:0]   divisor;
   } f2_type;

   typedef struct packed {
      pac_pkg::status_type             status;
      logic                            fsk;
      logic [3:0]                      sf;
      logic [18:0]                     base;
      logic [pac_pkg::DIVISOR_W-1:0]   divisor;
   } f3_type;

   typedef struct packed {
      pac_pkg::status_type             status;
      logic                            fsk;
      logic [3:0]                      sf;
      logic [41:0]                     prod;
      logic [pac_pkg::DIVISOR_W-1:0]   divisor;
   } f4_type;

   f1_type      f1_ff, f1_in;
   f2_type      f2_ff, f2_in;
   f3_type      f3_ff, f3_in;
   f4_type      f4_ff, f4_in;
   logic [3:0]  valid_ff;
   logic        advance;
   logic        crc_on;
   logic [12:0] pos, negp;
   logic [28:0] recip_prod;
   logic [9:0]  nsym;
   logic [18:0] quarters;

   // the whole front end moves together; only a full queue holds it
   assign advance = !valid_ff[3] || !q_full;
   assign full    = !advance;
   assign q_push  = valid_ff[3] && !q_full;

   // stage 1: classify; symbol count numerator, byte count, divisor
   always_comb begin
      crc_on = !req_data.crc_off;
      f1_in.sf  = req_data.rate_value[3:0];
      f1_in.cr  = req_data.coding_rate;
      f1_in.pre = req_data.preamble_len;
      f1_in.fsk = (req_data.modulation == pac_pkg::MOD_FSK);
      unique case (req_data.modulation)
         pac_pkg::MOD_CHIRP: begin
            if (req_data.bandwidth_code == 3'd7) begin
               f1_in.status = pac_pkg::STATUS_BAD_BW;
            end else if (req_data.rate_value < pac_pkg::SF_MIN ||
                         req_data.rate_value > pac_pkg::SF_MAX) begin
               f1_in.status = pac_pkg::STATUS_BAD_SF;
            end else begin
               f1_in.status = pac_pkg::STATUS_OK;
            end
         end
         pac_pkg::MOD_FSK: begin
            f1_in.status = (req_data.rate_value == '0) ? pac_pkg::STATUS_ZERO_RATE
                                                       : pac_pkg::STATUS_OK;
         end
         default: f1_in.status = pac_pkg::STATUS_BAD_MOD;
      endcase
      pos  = 13'({req_data.payload_bytes, 3'b000}) + 13'd28 + (crc_on ? 13'd16 : 13'd0);
      negp = 13'({req_data.rate_value[3:0], 2'b00})
             + (req_data.header_off ? 13'd20 : 13'd0);
      // clamp a non-positive numerator to a zero ceiling
      f1_in.qnum = (pos > negp)
                   ? pos - negp + 13'(pac_pkg::sf_den_m1(req_data.rate_value[3:0]))
                   : '0;
      f1_in.recip = pac_pkg::sf_recip(req_data.rate_value[3:0]);
      f1_in.bytes = 17'(req_data.preamble_len) + 17'(sync_bytes) + 17'd1
                    + 17'(req_data.payload_bytes) + (crc_on ? 17'd2 : 17'd0);
      f1_in.divisor = f1_in.fsk ? pac_pkg::DIVISOR_W'(req_data.rate_value)
                                : pac_pkg::bw_quad(req_data.bandwidth_code);
   end

   // stage 2: ceiling division by reciprocal multiply
   always_comb begin
      recip_prod     = 29'(f1_ff.qnum) * 29'(f1_ff.recip);
      f2_in.status   = f1_ff.status;
      f2_in.fsk      = f1_ff.fsk;
      f2_in.sf       = f1_ff.sf;
      f2_in.cr       = f1_ff.cr;
      f2_in.pre      = f1_ff.pre;
      f2_in.q        = recip_prod[26:20];
      f2_in.bytes    = f1_ff.bytes;
      f2_in.divisor  = f1_ff.divisor;
   end

   // stage 3: total length in quarter symbols, or in bytes for FSK
   always_comb begin
      nsym     = 10'd8 + 10'(f2_ff.q) * 10'({1'b0, f2_ff.cr} + 4'd4);
      quarters = 19'({f2_ff.pre, 2'b00}) + 19'd17 + 19'({nsym, 2'b00});
      f3_in.status  = f2_ff.status;
      f3_in.fsk     = f2_ff.fsk;
      f3_in.sf      = f2_ff.sf;
      f3_in.base    = f2_ff.fsk ? 19'(f2_ff.bytes) : quarters;
      f3_in.divisor = f2_ff.divisor;
   end

   // stage 4: scale to microseconds
   always_comb begin
      f4_in.status  = f3_ff.status;
      f4_in.fsk     = f3_ff.fsk;
      f4_in.sf      = f3_ff.sf;
      f4_in.prod    = 42'(f3_ff.base)
                      * 42'(f3_ff.fsk ? pac_pkg::FSK_SCALE : pac_pkg::CHIRP_SCALE);
      f4_in.divisor = f3_ff.divisor;
   end

   always_comb begin
      q_data.dividend = f4_ff.fsk ? pac_pkg::DIVIDEND_W'(f4_ff.prod)
                                  : pac_pkg::DIVIDEND_W'(f4_ff.prod) << f4_ff.sf;
      q_data.divisor  = f4_ff.divisor;
      q_data.status   = f4_ff.status;
      q_data.fsk      = f4_ff.fsk;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[2:0], push};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_ff <= f1_in;
         f2_ff <= f2_in;
         f3_ff <= f3_in;
         f4_ff <= f4_in;
      end
   end

endmodule

`default_nettype wire

@@ src/pac_divider.sv @@
// Back end: pipelined restoring divider, one quotient bit per stage, with
// saturation and the result register. Depends on pac_pkg.
`default_nettype none

module pac_divider (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            q_empty,
   input  wire pac_pkg::op_type q_data,
   output logic                 q_pop,
   output logic                 empty,
   input  wire logic            pop,
   output pac_pkg::rsp_type     rsp_data
);

   localparam int STEPS = pac_pkg::QUOT_W;
   localparam int EXT_W = pac_pkg::DIVIDEND_W + 1;

   typedef struct packed {
      logic [pac_pkg::DIVIDEND_W-1:0] rem;
      logic [pac_pkg::DIVISOR_W-1:0]  divisor;
      logic [pac_pkg::QUOT_W-1:0]     quot;
      logic                           sat;
      pac_pkg::status_type            status;
      logic                           fsk;
   } stg_type;

   stg_type             stg_ff [STEPS+1];
   stg_type             stg_in [STEPS+1];
   logic [STEPS:0]      valid_ff;
   logic                out_valid_ff;
   pac_pkg::rsp_type    out_ff, out_in;
   logic                advance;

   assign advance  = !out_valid_ff || pop;
   assign q_pop    = advance && !q_empty;
   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

   always_comb begin
      stg_in[0].rem     = q_data.dividend;
      stg_in[0].divisor = q_data.divisor;
      stg_in[0].quot    = '0;
      // quotient would need more than 32 bits
      stg_in[0].sat     = {1'b0, q_data.dividend}
                          >= {q_data.divisor, {pac_pkg::QUOT_W{1'b0}}};
      stg_in[0].status  = q_data.status;
      stg_in[0].fsk     = q_data.fsk;
   end

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      logic [EXT_W-1:0] shifted, diff;
      always_comb begin
         shifted = EXT_W'(stg_ff[s].divisor) << (STEPS - 1 - s);
         diff    = {1'b0, stg_ff[s].rem} - shifted;
         stg_in[s+1]      = stg_ff[s];
         stg_in[s+1].quot = {stg_ff[s].quot[pac_pkg::QUOT_W-2:0], !diff[EXT_W-1]};
         if (!diff[EXT_W-1]) begin
            stg_in[s+1].rem = diff[pac_pkg::DIVIDEND_W-1:0];
         end
      end
   end

   always_comb begin
      out_in.status = stg_ff[STEPS].status;
      priority if (stg_ff[STEPS].status != pac_pkg::STATUS_OK) begin
         out_in.airtime_us = '0;
      end else if (stg_ff[STEPS].sat) begin
         out_in.airtime_us = '1;
      end else if (stg_ff[STEPS].fsk) begin
         // FSK adds one microsecond, still saturating
         out_in.airtime_us = (&stg_ff[STEPS].quot) ? '1 : stg_ff[STEPS].quot + 1'b1;
      end else begin
         out_in.airtime_us = stg_ff[STEPS].quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[STEPS-1:0], !q_empty};
         out_valid_ff <= valid_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stg_ff <= stg_in;
         out_ff <= out_in;
      end
   end

endmodule

`default_nettype wire

@@ tb/packet_airtime_calculator_tb.sv @@
// Testbench for packet_airtime_calculator: directed table plus random descriptors,
// each checked against known results or an air-time predictor. Depends on pac_pkg.
`timescale 1ns / 1ps

module packet_airtime_calculator_tb;

   localparam int       CLK_PERIOD  = 8;
   localparam int       DRAIN_WAIT  = 60;
   localparam int       CYCLE_LIMIT = 2000000;
   localparam int       RANDOM_ITEMS = 500;
   localparam int       LONG_STALL  = 300;
   localparam [31:0]    AIR_SAT     = 32'hFFFF_FFFF;
   localparam [1:0]     MOD_BAD2    = 2'd2;
   localparam [1:0]     MOD_BAD3    = 2'd3;
   localparam [2:0]     BW_INVALID  = 3'd7;

   typedef struct {
      pac_pkg::req_type d;
      bit               known;
      pac_pkg::rsp_type r;
   } vector_type;

   logic clock;
   logic reset;
   logic push;
   logic full;
   pac_pkg::req_type req_data;
   logic empty;
   logic pop;
   pac_pkg::rsp_type rsp_data;
   logic psel;
   logic penable;
   logic pwrite;
   logic [pac_pkg::CSR_ADDR_W-1:0] paddr;
   logic [pac_pkg::CSR_DATA_W-1:0] pwdata;
   logic [pac_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   pac_pkg::rsp_type airtime_pending[$];
   logic [pac_pkg::SYNC_W-1:0] sync_bytes;
   int mismatches;
   int cycles;
   int send_idle;
   int recv_idle;
   logic stall_request;
   int stall_left;

   packet_airtime_calculator DUT (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("packet_airtime_calculator_tb: FAIL");
         $finish;
      end
   end

   function automatic pac_pkg::rsp_type predict_airtime(pac_pkg::req_type d,
                                                        logic [pac_pkg::SYNC_W-1:0] sync);
      pac_pkg::rsp_type r;
      longint unsigned bw, quarters, t, nsym, bytes;
      longint num, den, q, sf;
      r.airtime_us = '0;
      r.status = pac_pkg::STATUS_OK;
      t = 0;
      case (d.bandwidth_code)
         3'd0: bw = 500000;
         3'd1: bw = 250000;
         3'd2: bw = 125000;
         3'd3: bw = 62500;
         3'd4: bw = 31200;
         3'd5: bw = 15600;
         default: bw = 7800;
      endcase
      if (d.modulation == pac_pkg::MOD_CHIRP) begin
         if (d.bandwidth_code == BW_INVALID)
            r.status = pac_pkg::STATUS_BAD_BW;
         else if (d.rate_value < 7 || d.rate_value > 12)
            r.status = pac_pkg::STATUS_BAD_SF;
         else begin
            sf = longint'(d.rate_value);
            num = 8 * longint'(d.payload_bytes) - 4 * sf + 28
                  + (d.crc_off ? 0 : 16) - (d.header_off ? 20 : 0);
            den = 4 * (sf - ((sf >= 11) ? 2 : 0));
            q = (num > 0) ? (num + den - 1) / den : 0;
            nsym = 8 + q * (longint'(d.coding_rate) + 4);
            quarters = 4 * longint'(d.preamble_len) + 17 + 4 * nsym;
            t = ((quarters << sf) * 1000000) / (4 * bw);
         end
      end else if (d.modulation == pac_pkg::MOD_FSK) begin
         if (d.rate_value == 0)
            r.status = pac_pkg::STATUS_ZERO_RATE;
         else begin
            bytes = longint'(d.preamble_len) + sync + 1 + d.payload_bytes
                    + (d.crc_off ? 0 : 2);
            t = (bytes * 8000000) / longint'(d.rate_value) + 1;
         end
      end else
         r.status = pac_pkg::STATUS_BAD_MOD;
      r.airtime_us = (t > AIR_SAT) ? AIR_SAT : t[31:0];
      return r;
   endfunction

   // result side: check each transfer, then pick pop for the next edge
   always @(posedge clock) begin
      pac_pkg::rsp_type want;
      if (reset) begin
         pop <= 1'b0;
         stall_left <= 0;
      end else begin
         if (pop && !empty) begin
            if (airtime_pending.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result airtime=%0d status=%0d",
                        $time, rsp_data.airtime_us, rsp_data.status);
            end else begin
               want = airtime_pending.pop_front();
               if (rsp_data.airtime_us !== want.airtime_us) begin
                  mismatches++;
                  $display("%0t: airtime_us expected %0d actual %0d",
                           $time, want.airtime_us, rsp_data.airtime_us);
               end
               if (rsp_data.status !== want.status) begin
                  mismatches++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_data.status);
               end
            end
         end
         if (stall_request) begin
            stall_left <= LONG_STALL;
            pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            pop <= 1'b0;
         end else
            pop <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic send_descriptor(input pac_pkg::req_type d, input bit known,
                                  input pac_pkg::rsp_type r);
      while ($urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data <= d;
      do @(posedge clock); while (full);
      airtime_pending.push_back(known ? r : predict_airtime(d, sync_bytes));
   endtask

   task automatic write_sync(input logic [pac_pkg::CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= pac_pkg::CSR_ADDR_SYNC;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      sync_bytes = value[pac_pkg::SYNC_W-1:0];
   endtask

   task automatic drain;
      push <= 1'b0;
      while (airtime_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic pac_pkg::req_type random_descriptor();
      pac_pkg::req_type d;
      logic [63:0] raw;
      int pick;
      raw = {$urandom, $urandom};
      d = raw[$bits(pac_pkg::req_type)-1:0];
      pick = int'($urandom_range(99));
      if (pick < 55) begin
         d.modulation = pac_pkg::MOD_CHIRP;
         d.bandwidth_code = 3'($urandom_range(6));
         d.rate_value = 19'($urandom_range(12, 7));
         if ($urandom_range(3) != 0) d.coding_rate = 3'($urandom_range(4, 1));
         if ($urandom_range(3) != 0) d.preamble_len = 16'($urandom_range(64));
      end else if (pick < 85) begin
         d.modulation = pac_pkg::MOD_FSK;
         if ($urandom_range(3) != 0) d.rate_value = 19'($urandom_range(300000, 1));
         if ($urandom_range(3) != 0) d.preamble_len = 16'($urandom_range(64));
      end
      return d;
   endfunction

   function automatic vector_type row(input logic [1:0] m, input logic [2:0] bw,
         input logic [18:0] rate, input logic [2:0] cr, input logic [15:0] pre,
         input logic [7:0] pay, input logic crc_off, input logic hdr_off,
         input bit known, input logic [31:0] air, input pac_pkg::status_type st);
      vector_type v;
      v.d = '{m, bw, rate, cr, pre, pay, crc_off, hdr_off};
      v.known = known;
      v.r.airtime_us = air;
      v.r.status = st;
      return v;
   endfunction

   initial begin
      vector_type directed[$];
      pac_pkg::rsp_type none;
      logic [pac_pkg::CSR_DATA_W-1:0] sync_plan[3];
      none = '0;
      cycles <= 0;
      mismatches = 0;
      sync_bytes = pac_pkg::SYNC_RESET;
      send_idle = 13;
      recv_idle = 67;
      stall_request <= 1'b0;
      reset <= 1'b1;
      push <= 1'b0;
      req_data <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed = '{
         row(MOD_BAD2, 3'd0, 19'd7, 3'd1, 16'd8, 8'd10, 1'b0, 1'b0, 1'b1, '0,
             pac_pkg::STATUS_BAD_MOD),
         row(MOD_BAD3, 3'd7, 19'h7FFFF, 3'd7, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b1, '0,
             pac_pkg::STATUS_BAD_MOD),
         row(pac_pkg::MOD_CHIRP, BW_INVALID, 19'd3, 3'd1, 16'd8, 8'd10, 1'b0, 1'b0,
             1'b1, '0, pac_pkg::STATUS_BAD_BW),
         row(pac_pkg::MOD_CHIRP, 3'd0, 19'd6, 3'd1, 16'd8, 8'd10, 1'b0, 1'b0, 1'b1, '0,
             pac_pkg::STATUS_BAD_SF),
         row(pac_pkg::MOD_CHIRP, 3'd2, 19'd13, 3'd1, 16'd8, 8'd10, 1'b0, 1'b0, 1'b1, '0,
             pac_pkg::STATUS_BAD_SF),
         row(pac_pkg::MOD_CHIRP, 3'd2, 19'h7FFFF, 3'd1, 16'd8, 8'd10, 1'b0, 1'b0, 1'b1,
             '0, pac_pkg::STATUS_BAD_SF),
         row(pac_pkg::MOD_FSK, 3'd0, 19'd0, 3'd0, 16'd5, 8'd10, 1'b0, 1'b0, 1'b1, '0,
             pac_pkg::STATUS_ZERO_RATE),
         row(pac_pkg::MOD_CHIRP, 3'd6, 19'd12, 3'd7, 16'hFFFF, 8'hFF, 1'b0, 1'b0, 1'b1,
             AIR_SAT, pac_pkg::STATUS_OK),
         row(pac_pkg::MOD_FSK, 3'd7, 19'd1, 3'd7, 16'hFFFF, 8'hFF, 1'b0, 1'b0, 1'b1,
             AIR_SAT, pac_pkg::STATUS_OK),
         row(pac_pkg::MOD_CHIRP, 3'd0, 19'd7, 3'd0, 16'd0, 8'd0, 1'b1, 1'b1, 1'b0, '0,
             pac_pkg::STATUS_OK),
         row(pac_pkg::MOD_CHIRP, 3'd1, 19'd8, 3'd1, 16'd8, 8'd20, 1'b0, 1'b0, 1'b0, '0,
             pac_pkg::STATUS_OK),
         row(pac_pkg::MOD_CHIRP, 3'd2, 19'd9, 3'd2, 16'd8, 8'd51, 1'b0, 1'b1, 1'b0, '0,
             pac_pkg::STATUS_OK),
         row(pac_pkg::MOD_CHIRP, 3'd3, 19'd10, 3'd3, 16'd12, 8'd100, 1'b1, 1'b0, 1'b0,
             '0, pac_pkg::STATUS_OK),
         row(pac_pkg::MOD_CHIRP, 3'd4, 19'd11, 3'd4, 16'd8, 8'd1, 1'b0, 1'b0, 1'b0, '0,
             pac_pkg::STATUS_OK),
         row(pac_pkg::MOD_CHIRP, 3'd5, 19'd12, 3'd5, 16'd6, 8'd255, 1'b0, 1'b0, 1'b0, '0,
             pac_pkg::STATUS_OK),
         row(pac_pkg::MOD_CHIRP, 3'd6, 19'd12, 3'd6, 16'd6, 8'd0, 1'b1, 1'b1, 1'b0, '0,
             pac_pkg::STATUS_OK),
         row(pac_pkg::MOD_CHIRP, 3'd0, 19'd7, 3'd7, 16'd8, 8'd255, 1'b0, 1'b0, 1'b0, '0,
             pac_pkg::STATUS_OK),
         row(pac_pkg::MOD_FSK, 3'd0, 19'd50000, 3'd0, 16'd5, 8'd0, 1'b1, 1'b0, 1'b0, '0,
             pac_pkg::STATUS_OK),
         row(pac_pkg::MOD_FSK, 3'd3, 19'd300000, 3'd5, 16'd0, 8'd255, 1'b0, 1'b1, 1'b0,
             '0, pac_pkg::STATUS_OK),
         row(pac_pkg::MOD_FSK, 3'd7, 19'h7FFFF, 3'd7, 16'hFFFF, 8'hFF, 1'b0, 1'b1, 1'b0,
             '0, pac_pkg::STATUS_OK),
         row(pac_pkg::MOD_FSK, 3'd1, 19'd1200, 3'd2, 16'd3, 8'd16, 1'b0, 1'b0, 1'b0, '0,
             pac_pkg::STATUS_OK)
      };
      foreach (directed[i]) send_descriptor(directed[i].d, directed[i].known, directed[i].r);
      drain();

      // sender/receiver idle mix per phase; sync extremes and beyond the nominal range
      sync_plan = '{32'd0, 32'd15, 32'd8};
      for (int phase = 0; phase < 3; phase++) begin
         write_sync(sync_plan[phase]);
         send_idle = (phase == 0) ? 13 : (phase == 1) ? 67 : 0;
         recv_idle = (phase == 0) ? 67 : (phase == 1) ? 13 : 0;
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
            if (phase == 2 && n == 10) begin
               // hold the input for this edge so nothing is sent twice
               push <= 1'b0;
               stall_request <= 1'b1;
               @(posedge clock);
               stall_request <= 1'b0;
            end
            send_descriptor(random_descriptor(), 1'b0, none);
         end
         drain();
      end

      if (mismatches == 0)
         $display("packet_airtime_calculator_tb: PASS");
      else
         $display("packet_airtime_calculator_tb: FAIL");
      $finish;
   end

endmodule

@@ packet_airtime_calculator.f @@
src/pac_pkg.sv
src/pac_ram_queue.sv
src/pac_front.sv
src/pac_divider.sv
src/packet_airtime_calculator.sv
tb/packet_airtime_calculator_tb.sv
